### rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cdad_pkg.sv
// Package with types, constants, microcode encoding and the month length table.
`timescale 1ns / 1ps

package cdad_pkg;

  // Largest year a result may carry.
  localparam int MAX_YEAR = 9999;
  localparam int MONTHS   = 12;
  localparam int MONTH_WRAP = 13;

  // Widths of the working registers. The day count covers every date up to
  // year 65535 plus the largest offset, with a sign bit.
  localparam int ACC_W  = 26;
  localparam int YR_W   = 17;
  localparam int STEP_W = 5;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [YR_W-1:0]         yr_t;
  typedef logic [STEP_W-1:0]       step_t;

  // Days per calendar block.
  localparam acc_t DAYS_400Y = acc_t'(146097);
  localparam acc_t DAYS_100Y = acc_t'(36524);
  localparam acc_t DAYS_4Y   = acc_t'(1461);
  localparam acc_t DAYS_1Y   = acc_t'(365);

  // Index of the last four-year block in a century; that block has no leap day unless the
  // century is the fourth of its 400-year cycle.
  localparam logic [4:0] QUADS_PER_CENT = 5'd24;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_SET_ERR,
    OP_SUB400,
    OP_SUB100,
    OP_SUB4,
    OP_SUB1,
    OP_ADD_MONTH,
    OP_ADD_OFF,
    OP_DEC400,
    OP_DEC100,
    OP_DEC4,
    OP_DEC1,
    OP_DEC_MONTH,
    OP_FINISH
  } op_t;

  // Branch conditions.
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_BAD_INPUT,
    C_REM_GE400,
    C_REM_GE100,
    C_REM_GE4,
    C_REM_GE1,
    C_MO_LT_BASE,
    C_DAY_BAD,
    C_ACC_NEG,
    C_ACC_GE400Y,
    C_ACC_GE100Y,
    C_ACC_GE4Y,
    C_ACC_GE1Y,
    C_YR_BIG,
    C_MONTH_MORE,
    C_OUT_FULL
  } cond_t;

  // One control word: when the condition holds, the operation runs and the
  // step counter loads the target; otherwise the counter advances by one.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  // Program addresses.
  localparam step_t ST_CHECK    = step_t'(0);
  localparam step_t ST_Y400     = step_t'(1);
  localparam step_t ST_Y100     = step_t'(2);
  localparam step_t ST_Y4       = step_t'(3);
  localparam step_t ST_Y1       = step_t'(4);
  localparam step_t ST_MSUM     = step_t'(5);
  localparam step_t ST_DCHK     = step_t'(6);
  localparam step_t ST_OFF      = step_t'(7);
  localparam step_t ST_NEG      = step_t'(8);
  localparam step_t ST_S400     = step_t'(9);
  localparam step_t ST_S100     = step_t'(10);
  localparam step_t ST_S4       = step_t'(11);
  localparam step_t ST_S1       = step_t'(12);
  localparam step_t ST_YCHK     = step_t'(13);
  localparam step_t ST_MWALK    = step_t'(14);
  localparam step_t ST_FIN_WAIT = step_t'(15);
  localparam step_t ST_FINISH   = step_t'(16);

  // Sequencer run state.
  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    op_t  op;
  } ctrl_t;

  // Status from the datapath to the sequencer, one bit per condition other than C_ALWAYS.
  typedef struct packed {
    logic bad_input;
    logic rem_ge400;
    logic rem_ge100;
    logic rem_ge4;
    logic rem_ge1;
    logic mo_lt_base;
    logic day_bad;
    logic acc_neg;
    logic acc_ge400y;
    logic acc_ge100y;
    logic acc_ge4y;
    logic acc_ge1y;
    logic yr_big;
    logic month_more;
    logic out_full;
  } flags_t;

  // Length of month m, with February taking the leap flag.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/cdad_ucode_rom.sv
// Microcode store: the control word for each program step.
`timescale 1ns / 1ps

module cdad_ucode_rom (
  input  cdad_pkg::step_t  step,
  output cdad_pkg::uword_t word
);

  // Program. Loops are single words that branch to themselves.
  always_comb begin
    case (step)
      // Reject a zero year, month or day, or a year or month beyond range.
      cdad_pkg::ST_CHECK: word = '{cdad_pkg::OP_SET_ERR, cdad_pkg::C_BAD_INPUT,
                                   cdad_pkg::ST_FIN_WAIT};
      // Count days of the whole years before the base year.
      cdad_pkg::ST_Y400:  word = '{cdad_pkg::OP_SUB400, cdad_pkg::C_REM_GE400,
                                   cdad_pkg::ST_Y400};
      cdad_pkg::ST_Y100:  word = '{cdad_pkg::OP_SUB100, cdad_pkg::C_REM_GE100,
                                   cdad_pkg::ST_Y100};
      cdad_pkg::ST_Y4:    word = '{cdad_pkg::OP_SUB4, cdad_pkg::C_REM_GE4,
                                   cdad_pkg::ST_Y4};
      cdad_pkg::ST_Y1:    word = '{cdad_pkg::OP_SUB1, cdad_pkg::C_REM_GE1,
                                   cdad_pkg::ST_Y1};
      // Add the months before the base month.
      cdad_pkg::ST_MSUM:  word = '{cdad_pkg::OP_ADD_MONTH, cdad_pkg::C_MO_LT_BASE,
                                   cdad_pkg::ST_MSUM};
      // The day must fit its month.
      cdad_pkg::ST_DCHK:  word = '{cdad_pkg::OP_SET_ERR, cdad_pkg::C_DAY_BAD,
                                   cdad_pkg::ST_FIN_WAIT};
      cdad_pkg::ST_OFF:   word = '{cdad_pkg::OP_ADD_OFF, cdad_pkg::C_ALWAYS,
                                   cdad_pkg::ST_NEG};
      cdad_pkg::ST_NEG:   word = '{cdad_pkg::OP_SET_ERR, cdad_pkg::C_ACC_NEG,
                                   cdad_pkg::ST_FIN_WAIT};
      // Convert the day count back into years.
      cdad_pkg::ST_S400:  word = '{cdad_pkg::OP_DEC400, cdad_pkg::C_ACC_GE400Y,
                                   cdad_pkg::ST_S400};
      cdad_pkg::ST_S100:  word = '{cdad_pkg::OP_DEC100, cdad_pkg::C_ACC_GE100Y,
                                   cdad_pkg::ST_S100};
      cdad_pkg::ST_S4:    word = '{cdad_pkg::OP_DEC4, cdad_pkg::C_ACC_GE4Y,
                                   cdad_pkg::ST_S4};
      cdad_pkg::ST_S1:    word = '{cdad_pkg::OP_DEC1, cdad_pkg::C_ACC_GE1Y,
                                   cdad_pkg::ST_S1};
      cdad_pkg::ST_YCHK:  word = '{cdad_pkg::OP_SET_ERR, cdad_pkg::C_YR_BIG,
                                   cdad_pkg::ST_FIN_WAIT};
      // Walk the months of the result year.
      cdad_pkg::ST_MWALK: word = '{cdad_pkg::OP_DEC_MONTH, cdad_pkg::C_MONTH_MORE,
                                   cdad_pkg::ST_MWALK};
      // Hold until the output register is free, then deliver.
      cdad_pkg::ST_FIN_WAIT: word = '{cdad_pkg::OP_NOP, cdad_pkg::C_OUT_FULL,
                                      cdad_pkg::ST_FIN_WAIT};
      cdad_pkg::ST_FINISH: word = '{cdad_pkg::OP_FINISH, cdad_pkg::C_ALWAYS,
                                    cdad_pkg::ST_CHECK};
      default:            word = '{cdad_pkg::OP_NOP, cdad_pkg::C_ALWAYS,
                                   cdad_pkg::ST_FIN_WAIT};
    endcase
  end

endmodule

### rtl/cdad_sequencer.sv
// Sequencer: step counter, branch selection and the run state.
`timescale 1ns / 1ps

module cdad_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cdad_pkg::flags_t  flags,
  output cdad_pkg::ctrl_t   ctrl
);

  cdad_pkg::seq_state_t state;
  cdad_pkg::seq_state_t state_next;
  cdad_pkg::step_t      step;
  cdad_pkg::uword_t     word;
  logic                 cond_true;

  cdad_ucode_rom u_rom (
    .step (step),
    .word (word)
  );

  // Branch condition selected by the current control word.
  always_comb begin
    case (word.cond)
      cdad_pkg::C_ALWAYS:     cond_true = 1'b1;
      cdad_pkg::C_BAD_INPUT:  cond_true = flags.bad_input;
      cdad_pkg::C_REM_GE400:  cond_true = flags.rem_ge400;
      cdad_pkg::C_REM_GE100:  cond_true = flags.rem_ge100;
      cdad_pkg::C_REM_GE4:    cond_true = flags.rem_ge4;
      cdad_pkg::C_REM_GE1:    cond_true = flags.rem_ge1;
      cdad_pkg::C_MO_LT_BASE: cond_true = flags.mo_lt_base;
      cdad_pkg::C_DAY_BAD:    cond_true = flags.day_bad;
      cdad_pkg::C_ACC_NEG:    cond_true = flags.acc_neg;
      cdad_pkg::C_ACC_GE400Y: cond_true = flags.acc_ge400y;
      cdad_pkg::C_ACC_GE100Y: cond_true = flags.acc_ge100y;
      cdad_pkg::C_ACC_GE4Y:   cond_true = flags.acc_ge4y;
      cdad_pkg::C_ACC_GE1Y:   cond_true = flags.acc_ge1y;
      cdad_pkg::C_YR_BIG:     cond_true = flags.yr_big;
      cdad_pkg::C_MONTH_MORE: cond_true = flags.month_more;
      cdad_pkg::C_OUT_FULL:   cond_true = flags.out_full;
      default:                cond_true = 1'b0;
    endcase
  end

  // Next run state.
  always_comb begin
    state_next = state;
    case (state)
      cdad_pkg::SEQ_IDLE: begin
        if (in_valid) begin
          state_next = cdad_pkg::SEQ_RUN;
        end
      end
      cdad_pkg::SEQ_RUN: begin
        if (cond_true && (word.op == cdad_pkg::OP_FINISH)) begin
          state_next = cdad_pkg::SEQ_IDLE;
        end
      end
      default: state_next = cdad_pkg::SEQ_IDLE;
    endcase
  end

  // Outputs of the run state.
  always_comb begin
    in_ready  = 1'b0;
    ctrl.load = 1'b0;
    ctrl.exec = 1'b0;
    ctrl.op   = word.op;
    case (state)
      cdad_pkg::SEQ_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      cdad_pkg::SEQ_RUN: begin
        ctrl.exec = cond_true;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Run state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdad_pkg::SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Step counter: restart on a new beat, branch or advance while running.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= cdad_pkg::ST_CHECK;
    end else if (ctrl.load) begin
      step <= cdad_pkg::ST_CHECK;
    end else if (state == cdad_pkg::SEQ_RUN) begin
      if (cond_true) begin
        step <= word.target;
      end else begin
        step <= cdad_pkg::step_t'(step + 1'b1);
      end
    end
  end

endmodule

### rtl/cdad_datapath.sv
// Datapath: day count accumulator, year and month registers, output register.
`timescale 1ns / 1ps

module cdad_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  cdad_pkg::ctrl_t      ctrl,
  input  logic [13:0]          base_year,
  input  logic [3:0]           base_month,
  input  logic [4:0]           base_day,
  input  logic signed [20:0]   day_offset,
  input  logic                 out_ready,
  output cdad_pkg::flags_t     flags,
  output logic                 out_valid,
  output logic [13:0]          result_year,
  output logic [3:0]           result_month,
  output logic [4:0]           result_day,
  output logic                 error_flag
);

  // Latched input beat.
  logic [13:0]         by;
  logic [3:0]          bm;
  logic [4:0]          bd;
  logic signed [20:0]  off;

  // Working registers.
  cdad_pkg::acc_t      acc;
  logic [13:0]         rem;
  cdad_pkg::yr_t       yr;
  logic [3:0]          mo;
  logic [1:0]          n100;
  logic [4:0]          n4;
  logic [1:0]          n1;
  logic                err;

  logic                leap;
  logic [4:0]          ml_cur;
  logic [4:0]          ml_base;
  cdad_pkg::acc_t      ml_ext;
  cdad_pkg::yr_t       max_yr;

  // The year in hand is leap when it is the fourth of its four-year block,
  // unless that block closes a century that is not the fourth of its cycle.
  assign leap = (n1 == 2'd3) && ((n4 != cdad_pkg::QUADS_PER_CENT) || (n100 == 2'd3));

  assign ml_cur  = cdad_pkg::month_len(mo, leap);
  assign ml_base = cdad_pkg::month_len(bm, leap);
  assign ml_ext  = cdad_pkg::acc_t'(ml_cur);
  assign max_yr  = cdad_pkg::yr_t'(cdad_pkg::MAX_YEAR);

  // Status for the sequencer's branches.
  always_comb begin
    flags.bad_input  = (by == 14'd0) || (cdad_pkg::yr_t'(by) > max_yr) ||
                       (bm == 4'd0) || (bm > 4'(cdad_pkg::MONTHS)) || (bd == 5'd0);
    flags.rem_ge400  = rem >= 14'd400;
    flags.rem_ge100  = rem >= 14'd100;
    flags.rem_ge4    = rem >= 14'd4;
    flags.rem_ge1    = rem != 14'd0;
    flags.mo_lt_base = mo < bm;
    flags.day_bad    = bd > ml_base;
    flags.acc_neg    = acc[cdad_pkg::ACC_W-1];
    flags.acc_ge400y = acc >= cdad_pkg::DAYS_400Y;
    flags.acc_ge100y = (acc >= cdad_pkg::DAYS_100Y) && (n100 != 2'd3);
    flags.acc_ge4y   = acc >= cdad_pkg::DAYS_4Y;
    flags.acc_ge1y   = (acc >= cdad_pkg::DAYS_1Y) && (n1 != 2'd3);
    flags.yr_big     = yr > max_yr;
    flags.month_more = (mo < 4'(cdad_pkg::MONTHS)) && (acc >= ml_ext);
    flags.out_full   = out_valid && !out_ready;
  end

  // Input latch.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      by  <= base_year;
      bm  <= base_month;
      bd  <= base_day;
      off <= day_offset;
    end
  end

  // Working registers, one operation per executed control word.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc  <= cdad_pkg::acc_t'(base_day) - cdad_pkg::acc_t'(1);
      rem  <= base_year - 14'd1;
      yr   <= cdad_pkg::yr_t'(1);
      mo   <= 4'd1;
      n100 <= 2'd0;
      n4   <= 5'd0;
      n1   <= 2'd0;
      err  <= 1'b0;
    end else if (ctrl.exec) begin
      case (ctrl.op)
        cdad_pkg::OP_SET_ERR: begin
          err <= 1'b1;
        end
        cdad_pkg::OP_SUB400: begin
          rem <= rem - 14'd400;
          acc <= acc + cdad_pkg::DAYS_400Y;
        end
        cdad_pkg::OP_SUB100: begin
          rem  <= rem - 14'd100;
          acc  <= acc + cdad_pkg::DAYS_100Y;
          n100 <= n100 + 2'd1;
        end
        cdad_pkg::OP_SUB4: begin
          rem <= rem - 14'd4;
          acc <= acc + cdad_pkg::DAYS_4Y;
          n4  <= n4 + 5'd1;
        end
        cdad_pkg::OP_SUB1: begin
          rem <= rem - 14'd1;
          acc <= acc + cdad_pkg::DAYS_1Y;
          n1  <= n1 + 2'd1;
        end
        cdad_pkg::OP_ADD_MONTH: begin
          acc <= acc + ml_ext;
          mo  <= mo + 4'd1;
        end
        cdad_pkg::OP_ADD_OFF: begin
          acc  <= acc + cdad_pkg::acc_t'(off);
          yr   <= cdad_pkg::yr_t'(1);
          mo   <= 4'd1;
          n100 <= 2'd0;
          n4   <= 5'd0;
          n1   <= 2'd0;
        end
        cdad_pkg::OP_DEC400: begin
          acc <= acc - cdad_pkg::DAYS_400Y;
          yr  <= yr + cdad_pkg::yr_t'(400);
        end
        cdad_pkg::OP_DEC100: begin
          acc  <= acc - cdad_pkg::DAYS_100Y;
          yr   <= yr + cdad_pkg::yr_t'(100);
          n100 <= n100 + 2'd1;
        end
        cdad_pkg::OP_DEC4: begin
          acc <= acc - cdad_pkg::DAYS_4Y;
          yr  <= yr + cdad_pkg::yr_t'(4);
          n4  <= n4 + 5'd1;
        end
        cdad_pkg::OP_DEC1: begin
          acc <= acc - cdad_pkg::DAYS_1Y;
          yr  <= yr + cdad_pkg::yr_t'(1);
          n1  <= n1 + 2'd1;
        end
        cdad_pkg::OP_DEC_MONTH: begin
          acc <= acc - ml_ext;
          mo  <= mo + 4'd1;
        end
        default: begin
          err <= err;
        end
      endcase
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.exec && (ctrl.op == cdad_pkg::OP_FINISH)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload: the input date is echoed on error.
  always_ff @(posedge clk) begin
    if (ctrl.exec && (ctrl.op == cdad_pkg::OP_FINISH)) begin
      error_flag <= err;
      if (err) begin
        result_year  <= by;
        result_month <= bm;
        result_day   <= bd;
      end else begin
        result_year  <= yr[13:0];
        result_month <= mo;
        result_day   <= acc[4:0] + 5'd1;
      end
    end
  end

endmodule

### rtl/calendar_date_add_days_unit.sv
// Operation: one beat runs a microprogram of 17 steps whose loops iterate per
// calendar block; a bad input field, a day beyond its month or a result before
// year 1 ends the program early, and every result may wait for the output
// register.
// Throughput: one beat at a time; the next beat is taken once the program
// has delivered its result into the output register.
// Reset: synchronous, active high; clears the sequencer and the output valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module calendar_date_add_days_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // base_year [13:0], base_month [17:14], base_day [22:18],
  // day_offset [43:23], zero fill [47:44]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_year [13:0], result_month [17:14], result_day [22:18],
  // zero fill [23]
  output logic [23:0] m_axis_tdata,
  // error_flag [0]
  output logic        m_axis_tuser
);

  cdad_pkg::ctrl_t  ctrl;
  cdad_pkg::flags_t flags;
  logic [13:0]      result_year;
  logic [3:0]       result_month;
  logic [4:0]       result_day;

  cdad_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  cdad_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .base_year    (s_axis_tdata[13:0]),
    .base_month   (s_axis_tdata[17:14]),
    .base_day     (s_axis_tdata[22:18]),
    .day_offset   ($signed(s_axis_tdata[43:23])),
    .out_ready    (m_axis_tready),
    .flags        (flags),
    .out_valid    (m_axis_tvalid),
    .result_year  (result_year),
    .result_month (result_month),
    .result_day   (result_day),
    .error_flag   (m_axis_tuser)
  );

  // Pack the result beat.
  assign m_axis_tdata = {1'b0, result_day, result_month, result_year};

  // A beat starts the program, so the input side closes right after it.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst,
               s_axis_tvalid && s_axis_tready, !s_axis_tready,
               "input ready while a beat is in work")
  // A new result only comes out of a running program.
  `ASSERT_SAME(a_result_from_run, clk, rst,
               $rose(m_axis_tvalid), $past(!s_axis_tready),
               "result appeared without a running program")
  // A good result carries a month in calendar range and a nonzero day.
  `ASSERT_SAME(a_result_range, clk, rst,
               m_axis_tvalid && !m_axis_tuser,
               (m_axis_tdata[17:14] != 4'd0) &&
               (m_axis_tdata[17:14] < 4'(cdad_pkg::MONTH_WRAP)) &&
               (m_axis_tdata[22:18] != 5'd0),
               "result month or day out of range")

endmodule

### dv/calendar_date_add_days_unit_tb.sv
// Self-checking testbench for the Gregorian date-plus-days unit.
`timescale 1ns / 1ps

module calendar_date_add_days_unit_tb;

  localparam int CLK_PERIOD    = 8;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 200;

  // Day counts of the Gregorian calendar blocks.
  localparam longint DAYS_PER_400 = 146097;
  localparam longint DAYS_PER_100 = 36524;
  localparam longint DAYS_PER_4   = 1461;
  localparam longint DAYS_PER_1   = 365;

  typedef struct {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        err;
  } date_result_t;

  // Predicts each shifted date and checks the unit's results in order.
  class date_scoreboard;
    date_result_t expected_dates[$];
    int mismatches = 0;
    int checked    = 0;
    int flagged    = 0;

    function bit leap_year(longint y);
      return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    endfunction

    function longint month_days(longint y, longint m);
      case (m)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        2:                     return leap_year(y) ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    // Converts the date to a day number, adds the offset, and converts back.
    function date_result_t shift_date(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                                      logic [20:0] off);
      date_result_t r;
      longint yy, serial, rest, q400, q100, q4, q1, mo;
      r.year  = y;
      r.month = m;
      r.day   = d;
      r.err   = 1'b1;
      if (y < 1 || y > cdad_pkg::MAX_YEAR || m < 1 || m > 12 || d < 1 ||
          d > month_days(y, m))
        return r;
      yy = longint'(y) - 1;
      serial = DAYS_PER_1 * yy + yy / 4 - yy / 100 + yy / 400 + longint'(d) - 1;
      for (mo = 1; mo < m; mo++)
        serial += month_days(y, mo);
      serial += longint'(signed'(off));
      if (serial < 0)
        return r;
      q400 = serial / DAYS_PER_400;
      rest = serial % DAYS_PER_400;
      q100 = rest / DAYS_PER_100;
      if (q100 > 3)
        q100 = 3;
      rest -= q100 * DAYS_PER_100;
      q4 = rest / DAYS_PER_4;
      rest -= q4 * DAYS_PER_4;
      q1 = rest / DAYS_PER_1;
      if (q1 > 3)
        q1 = 3;
      rest -= q1 * DAYS_PER_1;
      yy = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
      if (yy > cdad_pkg::MAX_YEAR)
        return r;
      mo = 1;
      while (mo < 12 && rest >= month_days(yy, mo)) begin
        rest -= month_days(yy, mo);
        mo++;
      end
      r.year  = yy[13:0];
      r.month = mo[3:0];
      r.day   = 5'(rest + 1);
      r.err   = 1'b0;
      return r;
    endfunction

    function void note_input(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                             logic [20:0] off);
      expected_dates.push_back(shift_date(y, m, d, off));
    endfunction

    function void check_result(logic [13:0] y, logic [3:0] m, logic [4:0] d, logic err);
      date_result_t want;
      if (expected_dates.size() == 0) begin
        $error("result beat with no date pending: year %0d month %0d day %0d flag %0b",
               y, m, d, err);
        mismatches++;
        return;
      end
      want = expected_dates.pop_front();
      checked++;
      if (want.err)
        flagged++;
      if (y !== want.year) begin
        $error("result_year: expected %0d, actual %0d", want.year, y);
        mismatches++;
      end
      if (m !== want.month) begin
        $error("result_month: expected %0d, actual %0d", want.month, m);
        mismatches++;
      end
      if (d !== want.day) begin
        $error("result_day: expected %0d, actual %0d", want.day, d);
        mismatches++;
      end
      if (err !== want.err) begin
        $error("error_flag: expected %0b, actual %0b", want.err, err);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  date_scoreboard date_sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  calendar_date_add_days_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Result side: check every accepted beat and stall at random.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      date_sb.check_result(m_axis_tdata[13:0], m_axis_tdata[17:14], m_axis_tdata[22:18],
                           m_axis_tuser);
    m_axis_tready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: end the run if neither side moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("calendar_date_add_days_unit verification failed");
        $finish;
      end
    end
  end

  // Present one date beat, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_date(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d,
                           input logic [20:0] off);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, off, d, m, y};
    do
      @(posedge clk);
    while (!s_axis_tready);
    date_sb.note_input(y, m, d, off);
  endtask

  // Mostly valid dates near and away from the year limits, some raw field noise.
  task automatic send_random_date();
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [20:0] off;
    if ($urandom_range(0, 99) < 12) begin
      y = 14'($urandom);
      m = 4'($urandom);
      d = 5'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       y = 14'($urandom_range(1, 4));
        1:       y = 14'($urandom_range(cdad_pkg::MAX_YEAR - 3, cdad_pkg::MAX_YEAR));
        default: y = 14'($urandom_range(1, cdad_pkg::MAX_YEAR));
      endcase
      m = 4'($urandom_range(1, 12));
      d = 5'($urandom_range(1, 32'(date_sb.month_days(y, m))));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: off = 21'(int'($urandom_range(0, 1460)) - 730);
      5, 6, 7, 8:    off = 21'($urandom);
      default:       off = $urandom_range(0, 1) ? 21'h0FFFFF : 21'h100001;
    endcase
    send_date(y, m, d, off);
  endtask

  // Hold the input idle until every pending date has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (date_sb.pending() != 0)
      @(posedge clk);
  endtask

  initial begin
    date_sb = new;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Sender idles often, receiver stalls most of the time.
    send_idle_pct  = 20;
    recv_stall_pct = 66;

    // Directed corners: leap days, month and year wraps, range limits, bad dates.
    send_date(14'd2024, 4'd2,  5'd29, 21'(0));
    send_date(14'd2023, 4'd3,  5'd1,  21'(-1));
    send_date(14'd2024, 4'd3,  5'd1,  21'(-1));
    send_date(14'd1900, 4'd2,  5'd28, 21'(1));
    send_date(14'd2000, 4'd2,  5'd28, 21'(1));
    send_date(14'd1600, 4'd2,  5'd29, 21'(365));
    send_date(14'd2021, 4'd12, 5'd31, 21'(1));
    send_date(14'd2021, 4'd1,  5'd1,  21'(-1));
    send_date(14'd1,    4'd1,  5'd1,  21'(0));
    send_date(14'd1,    4'd1,  5'd1,  21'(-1));
    send_date(14'd9999, 4'd12, 5'd31, 21'(1));
    send_date(14'd9999, 4'd12, 5'd31, 21'(-1048575));
    send_date(14'd1,    4'd1,  5'd1,  21'(1048575));
    send_date(14'd5000, 4'd6,  5'd15, 21'(1048575));
    send_date(14'd5000, 4'd6,  5'd15, 21'(-1048575));
    send_date(14'd5000, 4'd1,  5'd1,  21'(-1048576));
    send_date(14'd0,    4'd1,  5'd1,  21'(10));
    send_date(14'd16383, 4'd15, 5'd31, 21'h1FFFFF);
    send_date(14'd10000, 4'd1, 5'd1,  21'(0));
    send_date(14'd2021, 4'd0,  5'd1,  21'(5));
    send_date(14'd2021, 4'd13, 5'd1,  21'(5));
    send_date(14'd2021, 4'd4,  5'd31, 21'(5));
    send_date(14'd1900, 4'd2,  5'd29, 21'(5));
    send_date(14'd2021, 4'd1,  5'd0,  21'(5));

    // The sender waits here once for every result to return.
    drain_results();
    repeat (60) send_random_date();
    drain_results();

    // Sender idles most of the time, receiver rarely stalls.
    send_idle_pct  = 66;
    recv_stall_pct = 20;
    repeat (70) send_random_date();
    drain_results();

    // Full rate on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (70) send_random_date();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d shifted dates, %0d of them flagged as invalid or out of range,",
             date_sb.checked, date_sb.flagged);
    $display("under three pacing profiles of input idles and output stalls.");
    if (date_sb.mismatches == 0 && date_sb.pending() == 0) begin
      $display("calendar_date_add_days_unit verification clean");
    end else begin
      $display("calendar_date_add_days_unit verification failed");
    end
    $finish;
  end

endmodule
